// ===== design/pcm_to_float_ring_writer_macros.svh =====
// Assertion macros for the PCM to float ring writer.
`ifndef PCM_TO_FLOAT_RING_WRITER_MACROS_SVH
`define PCM_TO_FLOAT_RING_WRITER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PTF_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PTF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== design/ptf_pkg.sv =====
// Package with types, constants and the conversion function of the PCM to float ring writer.
`timescale 1ns / 1ps
package ptf_pkg;
    localparam int unsigned RING_FRAMES_DEFAULT = 4096;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_SAMPLE_BYTES = 2'd1;
    localparam logic [1:0] REG_FLOAT_SAMPLES = 2'd2;

    localparam logic [2:0] BYTES_ONE = 3'd1;
    localparam logic [2:0] BYTES_TWO = 3'd2;
    localparam logic [2:0] BYTES_FOUR = 3'd4;

    typedef enum logic [1:0] {
        FMT_ZERO,
        FMT_U8,
        FMT_S16,
        FMT_S32
    } fmt_t;

    typedef struct packed {
        logic [31:0] first_sample;
        logic [31:0] second_sample;
        logic        buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] first_float;
        logic [31:0] second_float;
        logic [11:0] ring_slot;
        logic        commit_now;
        logic [31:0] committed_position;
    } out_item_t;

    // Classified frame carried from the front part to the back part.
    typedef struct packed {
        fmt_t        fmt;
        logic        pass_first;
        logic        stereo;
        logic        neg_a;
        logic [31:0] mag_a;
        logic        neg_b;
        logic [31:0] mag_b;
        logic [31:0] raw_a;
        logic [31:0] raw_b;
        logic [11:0] ring_slot;
        logic        commit_now;
        logic [31:0] committed_position;
    } work_t;

    function automatic logic [31:0] to_single(logic neg, logic [31:0] mag, logic [4:0] k);
        logic [4:0]  p;
        logic [31:0] norm;
        logic [23:0] mant;
        logic [24:0] rnd;
        logic        guard;
        logic        sticky;
        logic [7:0]  expo;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                p = 5'(i);
            end
        end
        norm = mag << (5'd31 - p);
        mant = norm[31:8];
        guard = norm[7];
        sticky = |norm[6:0];
        rnd = {1'b0, mant} + 25'(guard && (sticky || mant[0]));
        expo = 8'(p) + 8'd127 - 8'(k);
        if (rnd[24])
        begin
            expo = expo + 8'd1;
        end
        if (mag == 32'd0)
        begin
            to_single = 32'd0;
        end
        else
        begin
            to_single = {neg, expo, rnd[24] ? rnd[23:1] : rnd[22:0]};
        end
    endfunction
endpackage

// ===== design/pcm_to_float_ring_writer.sv =====
// Top level of the PCM to float ring writer.
//  Channel  | Handshake        | Payload
//  input    | push / full      | in_data (in_item_t)
//  result   | pop / empty      | out_data (out_item_t)
//  config   | cfg_write        | cfg_index, cfg_data
// One frame per clock is sustained while results are popped; an accepted frame
// is written into the queue and then into the output register, where it is on
// the result ports. The front part keeps positions and classifies, a four-entry
// queue feeds the back part, which converts into an output register.
// Reset clears positions, queue pointers and valid flag; config takes defaults.
// full rises only when the queue fills while results are not popped.
`timescale 1ns / 1ps
module pcm_to_float_ring_writer #(
    parameter int unsigned RING_FRAMES = ptf_pkg::RING_FRAMES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ptf_pkg::in_item_t  in_data,
    input  logic               pop,
    output logic               empty,
    output ptf_pkg::out_item_t out_data,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data
);
    import ptf_pkg::*;

    work_t front_work;
    work_t queue_work;
    logic  queue_empty;
    logic  back_take;

    ptf_front #(.RING_FRAMES(RING_FRAMES)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .take(push && !full), .item(in_data), .work(front_work)
    );

    ptf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(front_work), .full(full),
        .pop(back_take), .pop_data(queue_work), .empty(queue_empty)
    );

    ptf_back u_back (
        .clk(clk), .rst_n(rst_n), .avail(!queue_empty), .work(queue_work),
        .take(back_take), .pop(pop), .empty(empty), .result(out_data)
    );
endmodule

// ===== design/ptf_front.sv =====
// Front part: configuration registers, format classification and ring position tracking.
`timescale 1ns / 1ps
module ptf_front #(
    parameter int unsigned RING_FRAMES = ptf_pkg::RING_FRAMES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [2:0]        cfg_data,
    input  logic              take,
    input  ptf_pkg::in_item_t item,
    output ptf_pkg::work_t    work
);
    import ptf_pkg::*;

    localparam int unsigned SLOT_BITS = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;

    logic [1:0]  channel_count_reg;
    logic [2:0]  sample_bytes_reg;
    logic        float_samples_reg;
    logic [31:0] running_position_reg;
    logic [31:0] visible_position_reg;
    logic [31:0] running_next;
    logic [SLOT_BITS-1:0] slot;
    logic [31:0] slot_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 2'd2;
            sample_bytes_reg <= 3'd2;
            float_samples_reg <= 1'b0;
            running_position_reg <= 32'd0;
            visible_position_reg <= 32'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[1:0];
                    REG_SAMPLE_BYTES: sample_bytes_reg <= cfg_data;
                    REG_FLOAT_SAMPLES: float_samples_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (take)
            begin
                running_position_reg <= running_next;
                if (item.buffer_end)
                begin
                    visible_position_reg <= running_next;
                end
            end
        end
    end

    assign running_next = running_position_reg + 32'd1;
    assign slot = running_position_reg[SLOT_BITS-1:0];
    assign slot_wide = 32'(slot);

    always_comb
    begin
        work.raw_a = item.first_sample;
        work.raw_b = item.second_sample;
        work.stereo = channel_count_reg[1];
        work.pass_first = 1'b0;
        work.fmt = FMT_ZERO;
        work.neg_a = 1'b0;
        work.neg_b = 1'b0;
        work.mag_a = 32'd0;
        work.mag_b = 32'd0;
        unique case (sample_bytes_reg)
            BYTES_ONE:
            begin
                work.fmt = FMT_U8;
                work.neg_a = !item.first_sample[7];
                work.neg_b = !item.second_sample[7];
                work.mag_a = work.neg_a ? 32'(8'd128 - item.first_sample[7:0])
                                        : 32'(item.first_sample[7:0] - 8'd128);
                work.mag_b = work.neg_b ? 32'(8'd128 - item.second_sample[7:0])
                                        : 32'(item.second_sample[7:0] - 8'd128);
                if (item.first_sample[7:0] == 8'd0)
                begin
                    work.mag_a = 32'd128;
                end
                if (item.second_sample[7:0] == 8'd0)
                begin
                    work.mag_b = 32'd128;
                end
            end
            BYTES_TWO:
            begin
                work.fmt = FMT_S16;
                work.neg_a = item.first_sample[15];
                work.neg_b = item.second_sample[15];
                work.mag_a = work.neg_a ? 32'(17'h10000 - {1'b0, item.first_sample[15:0]})
                                        : 32'(item.first_sample[15:0]);
                work.mag_b = work.neg_b ? 32'(17'h10000 - {1'b0, item.second_sample[15:0]})
                                        : 32'(item.second_sample[15:0]);
            end
            BYTES_FOUR:
            begin
                work.fmt = FMT_S32;
                work.pass_first = float_samples_reg;
                work.neg_a = item.first_sample[31];
                work.neg_b = item.second_sample[31];
                work.mag_a = work.neg_a ? 32'd0 - item.first_sample : item.first_sample;
                work.mag_b = work.neg_b ? 32'd0 - item.second_sample : item.second_sample;
            end
            default: work.fmt = FMT_ZERO;
        endcase
        work.ring_slot = slot_wide[11:0];
        work.commit_now = item.buffer_end;
        work.committed_position = item.buffer_end ? running_next : visible_position_reg;
    end
endmodule

// ===== design/ptf_queue.sv =====
// Short first-in first-out queue of classified frames between the front and back parts.
`timescale 1ns / 1ps
module ptf_queue #(
    parameter int unsigned DEPTH = ptf_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptf_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output ptf_pkg::work_t pop_data,
    output logic           empty
);
    import ptf_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_t          mem [DEPTH];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  rd_reg;
    logic [AW:0]    count_reg;

    assign full = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            end
            if (pop && !empty)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
            end
            count_reg <= count_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule

// ===== design/ptf_back.sv =====
// Back part: float packing of classified frames into a registered output stage.
`timescale 1ns / 1ps
module ptf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               avail,
    input  ptf_pkg::work_t     work,
    output logic               take,
    input  logic               pop,
    output logic               empty,
    output ptf_pkg::out_item_t result
);
    import ptf_pkg::*;

    logic      valid_reg;
    out_item_t result_reg;
    out_item_t result_next;
    logic [4:0] k;

    assign take = avail && (!valid_reg || pop);
    assign empty = !valid_reg;
    assign result = result_reg;

    always_comb
    begin
        unique case (work.fmt)
            FMT_U8: k = 5'd7;
            FMT_S16: k = 5'd15;
            FMT_S32: k = 5'd31;
            default: k = 5'd0;
        endcase
        result_next.first_float = 32'd0;
        result_next.second_float = 32'd0;
        if (work.fmt != FMT_ZERO)
        begin
            result_next.first_float = work.pass_first ? work.raw_a
                                                      : to_single(work.neg_a, work.mag_a, k);
            if (work.stereo)
            begin
                result_next.second_float = work.pass_first ? work.raw_b
                                                      : to_single(work.neg_b, work.mag_b, k);
            end
        end
        result_next.ring_slot = work.ring_slot;
        result_next.commit_now = work.commit_now;
        result_next.committed_position = work.committed_position;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end
endmodule

// ===== design/ptf_checker.sv =====
// Port-level checker for the PCM to float ring writer, with its bind.
`timescale 1ns / 1ps
`include "pcm_to_float_ring_writer_macros.svh"
module ptf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input ptf_pkg::out_item_t out_data
);
    import ptf_pkg::*;

    `PTF_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_data))
    `PTF_ASSERT_NEXT(a_push_fill, clk, rst_n, $past(rst_n && push && !full), !empty)
    `PTF_ASSERT_IMP(a_full_valid, clk, rst_n, full, !empty)
    `PTF_ASSERT_IMP(a_known, clk, rst_n, !empty, !$isunknown(out_data))
endmodule

bind pcm_to_float_ring_writer ptf_checker u_ptf_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .pop(pop),
    .empty(empty), .out_data(out_data)
);
